// ----- design/tps_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangle plane splitter package
// Shared payload, configuration and work-item types, plus corner tables.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

  localparam int DW = 51;
  localparam int NW = 52;

  localparam logic signed [31:0] NORMAL_X_RST     = 32'sd0;
  localparam logic signed [31:0] NORMAL_Y_RST     = 32'sd0;
  localparam logic signed [31:0] NORMAL_Z_RST     = 32'sd65536;
  localparam logic signed [31:0] PLANE_OFFSET_RST = 32'sd0;

  localparam logic [2:0] CORNER_V0    = 3'd0;
  localparam logic [2:0] CORNER_V1    = 3'd1;
  localparam logic [2:0] CORNER_V2    = 3'd2;
  localparam logic [2:0] CORNER_CUT_B = 3'd4;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
  } in_t;

  typedef struct packed {
    logic       split_done;
    logic       first_vertex_front;
    logic       piece_front;
    logic [2:0] corner_b;
    logic [2:0] corner_c;
    coord_t     cut_a_x;
    coord_t     cut_a_y;
    coord_t     cut_a_z;
    coord_t     cut_b_x;
    coord_t     cut_b_y;
    coord_t     cut_b_z;
    logic       last_piece;
  } out_t;

  typedef struct packed {
    coord_t normal_x;
    coord_t normal_y;
    coord_t normal_z;
    coord_t plane_offset;
  } cfg_t;

  typedef enum logic [1:0] {
    CFG_NORMAL_X     = 2'd0,
    CFG_NORMAL_Y     = 2'd1,
    CFG_NORMAL_Z     = 2'd2,
    CFG_PLANE_OFFSET = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SPLIT_NONE  = 2'd0,
    SPLIT_01_12 = 2'd1,
    SPLIT_01_20 = 2'd2,
    SPLIT_12_20 = 2'd3
  } split_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    vec_t            pa;
    vec_t            pb;
    logic [NW-1:0]   num;
    logic [NW-1:0]   den;
  } edge_t;

  typedef struct packed {
    split_t     kind;
    logic       fvf;
    logic [2:0] side;
    edge_t      cut_a;
    edge_t      cut_b;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_NORM = 3'd1,
    BK_DIV  = 3'd2,
    BK_MUL  = 3'd3,
    BK_ADD  = 3'd4,
    BK_EMIT = 3'd5
  } back_state_t;

  function automatic logic [2:0] corner_b_of(split_t kind, logic [1:0] n);
    logic [2:0] c;
    c = CORNER_V0;
    case (kind)
      SPLIT_01_12: begin
        case (n)
          2'd0:    c = CORNER_V1;
          2'd1:    c = CORNER_CUT_B;
          default: c = CORNER_V2;
        endcase
      end
      SPLIT_01_20: begin
        case (n)
          2'd0:    c = CORNER_V1;
          2'd1:    c = CORNER_V2;
          default: c = CORNER_CUT_B;
        endcase
      end
      SPLIT_12_20: begin
        case (n)
          2'd0:    c = CORNER_V2;
          2'd1:    c = CORNER_CUT_B;
          default: c = CORNER_V0;
        endcase
      end
      default: c = CORNER_V0;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] corner_c_of(split_t kind, logic [1:0] n);
    logic [2:0] c;
    c = CORNER_V0;
    case (kind)
      SPLIT_01_12: begin
        case (n)
          2'd0:    c = CORNER_CUT_B;
          2'd1:    c = CORNER_V2;
          default: c = CORNER_V0;
        endcase
      end
      SPLIT_01_20: begin
        case (n)
          2'd0:    c = CORNER_V2;
          2'd1:    c = CORNER_CUT_B;
          default: c = CORNER_V0;
        endcase
      end
      SPLIT_12_20: begin
        case (n)
          2'd0:    c = CORNER_CUT_B;
          2'd1:    c = CORNER_V0;
          default: c = CORNER_V1;
        endcase
      end
      default: c = CORNER_V0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/tps_front.sv -----
// ----------------------------------------------------------------------------
// Triangle plane splitter front end
// Two-stage distance pipeline followed by crossing classification.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_front
  import tps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  input  wire logic q_full,
  output logic      q_push,
  output job_t      q_wdata
);

  logic                 adv;
  logic                 s1_v_r;
  logic                 s2_v_r;
  vec_t                 vin [3];
  vec_t                 v1_r [3];
  vec_t                 v2_r [3];
  logic signed [63:0]   prod_r [3][3];
  logic signed [DW-1:0] d_r [3];
  logic [2:0]           pos;
  logic [2:0]           neg;
  logic [DW-1:0]        mag [3];
  logic                 c01;
  logic                 c12;
  logic                 c20;

  function automatic edge_t mk_edge(vec_t pa, vec_t pb, logic [DW-1:0] ma,
                                    logic [DW-1:0] mb);
    edge_t e;
    e.pa  = pa;
    e.pb  = pb;
    e.num = NW'(ma);
    e.den = NW'(ma) + NW'(mb);
    return e;
  endfunction

  assign vin[0] = {in_data.v0_x, in_data.v0_y, in_data.v0_z};
  assign vin[1] = {in_data.v1_x, in_data.v1_y, in_data.v1_z};
  assign vin[2] = {in_data.v2_x, in_data.v2_y, in_data.v2_z};

  assign adv      = !s2_v_r || !q_full;
  assign in_stall = !adv;
  assign q_push   = s2_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i][0] <= cfg.normal_x * vin[i].x;
        prod_r[i][1] <= cfg.normal_y * vin[i].y;
        prod_r[i][2] <= cfg.normal_z * vin[i].z;
        v1_r[i]      <= vin[i];
        d_r[i]       <= DW'(prod_r[i][0] >>> 16) + DW'(prod_r[i][1] >>> 16)
                      + DW'(prod_r[i][2] >>> 16) + DW'(cfg.plane_offset);
        v2_r[i]      <= v1_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i] = d_r[i][DW-1];
      pos[i] = !d_r[i][DW-1] && (d_r[i] != '0);
      mag[i] = d_r[i][DW-1] ? DW'(-d_r[i]) : DW'(d_r[i]);
    end
    c01 = (pos[0] && neg[1]) || (neg[0] && pos[1]);
    c12 = (pos[1] && neg[2]) || (neg[1] && pos[2]);
    c20 = (pos[2] && neg[0]) || (neg[2] && pos[0]);

    q_wdata      = '0;
    q_wdata.fvf  = pos[0];
    if (c01 && c12) begin
      q_wdata.kind  = SPLIT_01_12;
      q_wdata.side  = {pos[0], pos[2], pos[1]};
      q_wdata.cut_a = mk_edge(v2_r[0], v2_r[1], mag[0], mag[1]);
      q_wdata.cut_b = mk_edge(v2_r[1], v2_r[2], mag[1], mag[2]);
    end else if (c01 && c20) begin
      q_wdata.kind  = SPLIT_01_20;
      q_wdata.side  = {pos[0], pos[2], pos[1]};
      q_wdata.cut_a = mk_edge(v2_r[0], v2_r[1], mag[0], mag[1]);
      q_wdata.cut_b = mk_edge(v2_r[2], v2_r[0], mag[2], mag[0]);
    end else if (c12 && c20) begin
      q_wdata.kind  = SPLIT_12_20;
      q_wdata.side  = {pos[1], pos[0], pos[2]};
      q_wdata.cut_a = mk_edge(v2_r[1], v2_r[2], mag[1], mag[2]);
      q_wdata.cut_b = mk_edge(v2_r[2], v2_r[0], mag[2], mag[0]);
    end else begin
      q_wdata.kind  = SPLIT_NONE;
    end
  end

endmodule

`default_nettype wire

// ----- design/tps_queue.sv -----
// ----------------------------------------------------------------------------
// Triangle plane splitter job queue
// Small FIFO of classified triangles between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_queue
  import tps_pkg::*;
#(
  parameter int Depth = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t wdata,
  output logic      full,
  input  wire logic pop,
  output job_t      rdata,
  output logic      empty
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  job_t          mem [Depth];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(Depth));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- design/tps_back.sv -----
// ----------------------------------------------------------------------------
// Triangle plane splitter back end
// Bit-serial weight division, cut interpolation and piece emission.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_back
  import tps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire job_t q_rdata,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  back_state_t        st_r, st_nxt;
  job_t               job_r, job_nxt;
  logic [NW-1:0]      na_r, na_nxt, da_r, da_nxt;
  logic [NW-1:0]      nb_r, nb_nxt, db_r, db_nxt;
  logic [31:0]        ra_r, ra_nxt, rb_r, rb_nxt;
  logic [31:0]        qa_r, qa_nxt, qb_r, qb_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic signed [65:0] prod_r [6];
  logic signed [65:0] prod_nxt [6];
  coord_t             cut_r [6];
  coord_t             cut_nxt [6];
  logic [1:0]         pc_r, pc_nxt;
  logic               ov_r, ov_nxt;
  out_t               od_r, od_nxt;
  logic               ld;
  coord_t             pa [6];
  coord_t             pb [6];
  logic               big_a;
  logic               big_b;
  logic [30:0]        dza;
  logic [30:0]        dzb;
  logic signed [32:0] dl;

  function automatic logic [63:0] div_step(logic [31:0] r, logic [31:0] q,
                                           logic [30:0] den);
    logic [31:0] r2;
    r2 = {r[30:0], 1'b0};
    if (r2 >= {1'b0, den}) begin
      return {r2 - {1'b0, den}, q[30:0], 1'b1};
    end
    return {r2, q[30:0], 1'b0};
  endfunction

  assign ld        = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    pa[0] = job_r.cut_a.pa.x; pa[1] = job_r.cut_a.pa.y; pa[2] = job_r.cut_a.pa.z;
    pa[3] = job_r.cut_b.pa.x; pa[4] = job_r.cut_b.pa.y; pa[5] = job_r.cut_b.pa.z;
    pb[0] = job_r.cut_a.pb.x; pb[1] = job_r.cut_a.pb.y; pb[2] = job_r.cut_a.pb.z;
    pb[3] = job_r.cut_b.pb.x; pb[4] = job_r.cut_b.pb.y; pb[5] = job_r.cut_b.pb.z;
  end

  always_comb begin
    st_nxt  = st_r;
    job_nxt = job_r;
    na_nxt  = na_r;
    da_nxt  = da_r;
    nb_nxt  = nb_r;
    db_nxt  = db_r;
    ra_nxt  = ra_r;
    rb_nxt  = rb_r;
    qa_nxt  = qa_r;
    qb_nxt  = qb_r;
    cnt_nxt = cnt_r;
    pc_nxt  = pc_r;
    od_nxt  = od_r;
    ov_nxt  = ov_r && out_stall;
    q_pop   = 1'b0;
    big_a   = (da_r[NW-1:31] != '0);
    big_b   = (db_r[NW-1:31] != '0);
    dza     = (da_r == '0) ? 31'd1 : da_r[30:0];
    dzb     = (db_r == '0) ? 31'd1 : db_r[30:0];
    dl      = '0;
    for (int k = 0; k < 6; k++) begin
      prod_nxt[k] = prod_r[k];
      cut_nxt[k]  = cut_r[k];
    end

    case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_rdata.kind != SPLIT_NONE) begin
            q_pop   = 1'b1;
            job_nxt = q_rdata;
            na_nxt  = q_rdata.cut_a.num;
            da_nxt  = q_rdata.cut_a.den;
            nb_nxt  = q_rdata.cut_b.num;
            db_nxt  = q_rdata.cut_b.den;
            st_nxt  = BK_NORM;
          end else if (ld) begin
            q_pop                     = 1'b1;
            ov_nxt                    = 1'b1;
            od_nxt                    = '0;
            od_nxt.first_vertex_front = q_rdata.fvf;
            od_nxt.last_piece         = 1'b1;
          end
        end
      end
      BK_NORM: begin
        if (big_a) begin
          na_nxt = na_r >> 1;
          da_nxt = da_r >> 1;
        end
        if (big_b) begin
          nb_nxt = nb_r >> 1;
          db_nxt = db_r >> 1;
        end
        if (!big_a && !big_b) begin
          da_nxt  = NW'(dza);
          db_nxt  = NW'(dzb);
          qa_nxt  = (na_r[30:0] >= dza) ? 32'd1 : 32'd0;
          ra_nxt  = (na_r[30:0] >= dza) ? 32'(na_r[30:0] - dza) : 32'(na_r[30:0]);
          qb_nxt  = (nb_r[30:0] >= dzb) ? 32'd1 : 32'd0;
          rb_nxt  = (nb_r[30:0] >= dzb) ? 32'(nb_r[30:0] - dzb) : 32'(nb_r[30:0]);
          cnt_nxt = '0;
          st_nxt  = BK_DIV;
        end
      end
      BK_DIV: begin
        {ra_nxt, qa_nxt} = div_step(ra_r, qa_r, da_r[30:0]);
        {rb_nxt, qb_nxt} = div_step(rb_r, qb_r, db_r[30:0]);
        cnt_nxt          = cnt_r + 1'b1;
        if (cnt_r == 5'd30) begin
          st_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        for (int k = 0; k < 6; k++) begin
          dl          = 33'(pb[k]) - 33'(pa[k]);
          prod_nxt[k] = 66'(dl) * 66'($signed({1'b0, (k < 3) ? qa_r : qb_r}));
        end
        st_nxt = BK_ADD;
      end
      BK_ADD: begin
        for (int k = 0; k < 6; k++) begin
          cut_nxt[k] = 32'(66'(pa[k]) + (prod_r[k] >>> 31));
        end
        pc_nxt = '0;
        st_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (ld) begin
          ov_nxt                    = 1'b1;
          od_nxt.split_done         = 1'b1;
          od_nxt.first_vertex_front = job_r.fvf;
          od_nxt.piece_front        = job_r.side[pc_r];
          od_nxt.corner_b           = corner_b_of(job_r.kind, pc_r);
          od_nxt.corner_c           = corner_c_of(job_r.kind, pc_r);
          od_nxt.cut_a_x            = cut_r[0];
          od_nxt.cut_a_y            = cut_r[1];
          od_nxt.cut_a_z            = cut_r[2];
          od_nxt.cut_b_x            = cut_r[3];
          od_nxt.cut_b_y            = cut_r[4];
          od_nxt.cut_b_z            = cut_r[5];
          od_nxt.last_piece         = (pc_r == 2'd2);
          pc_nxt                    = pc_r + 1'b1;
          if (pc_r == 2'd2) begin
            st_nxt = BK_IDLE;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    na_r  <= na_nxt;
    da_r  <= da_nxt;
    nb_r  <= nb_nxt;
    db_r  <= db_nxt;
    ra_r  <= ra_nxt;
    rb_r  <= rb_nxt;
    qa_r  <= qa_nxt;
    qb_r  <= qb_nxt;
    cnt_r <= cnt_nxt;
    pc_r  <= pc_nxt;
    od_r  <= od_nxt;
    for (int k = 0; k < 6; k++) begin
      prod_r[k] <= prod_nxt[k];
      cut_r[k]  <= cut_nxt[k];
    end
  end

endmodule

`default_nettype wire

// ----- design/triangle_plane_splitter_top.sv -----
// ----------------------------------------------------------------------------
// Triangle plane splitter top level
// Gives three tagged pieces per triangle crossing the plane, else one beat.
// ----------------------------------------------------------------------------
// The front end takes one triangle per cycle, unless the queue is full,
// through a two-stage distance pipeline and hands classified triangles to a
// small queue. A triangle that is not split is popped and registered onto the
// output in one step, so such triangles stream at one per cycle while the
// output is not stalled. A split triangle holds the back end while it is
// taken from the queue, its weights are normalized, the bit-serial divider
// runs, a multiply and an add step interpolate and three beats leave. The
// divider sets the rate for split triangles, and output stalls add to it.
// Configuration writes are always accepted and must be issued while idle.
`default_nettype none

module triangle_plane_splitter_top
  import tps_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_t        in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_t            out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t cfg_r;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t q_wdata;
  job_t q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_x     <= NORMAL_X_RST;
      cfg_r.normal_y     <= NORMAL_Y_RST;
      cfg_r.normal_z     <= NORMAL_Z_RST;
      cfg_r.plane_offset <= PLANE_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NORMAL_X:     cfg_r.normal_x     <= cfg_data;
        CFG_NORMAL_Y:     cfg_r.normal_y     <= cfg_data;
        CFG_NORMAL_Z:     cfg_r.normal_z     <= cfg_data;
        CFG_PLANE_OFFSET: cfg_r.plane_offset <= cfg_data;
        default:          cfg_r.normal_x     <= cfg_r.normal_x;
      endcase
    end
  end

  tps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  tps_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_empty)
    else $error("queue full and empty at once");
`endif

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Triangle plane splitter testbench
// Drives triangles through the splitter under several plane settings. Each
// output beat is checked field by field against a predictor of the distance,
// crossing and fan-split logic. A few directed rows also carry a typed-in
// expected beat. Both sides idle at random, and at least once the output
// side holds off for a long time.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import tps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  triangle_plane_splitter_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    in_t  tri_in;
    bit   has_beat;
    out_t beat;
  } row_t;

  cfg_t   plane;
  row_t   rows[$];
  out_t   piece_q[$];
  out_t   typed_q[$];
  bit     typed_on_q[$];
  int     mismatches;
  int     cycles;
  int     n_tris;
  int     n_split;
  int     n_beats;
  bit     quiet;
  bit     hold_off;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [63:0] dist_of(coord_t x, coord_t y, coord_t z);
    logic signed [63:0] px, py, pz;
    px = 64'(plane.normal_x) * 64'(x);
    py = 64'(plane.normal_y) * 64'(y);
    pz = 64'(plane.normal_z) * 64'(z);
    return floor_shift(px, 16) + floor_shift(py, 16) + floor_shift(pz, 16)
           + 64'(plane.plane_offset);
  endfunction

  function automatic bit sign_flip(logic signed [63:0] a, logic signed [63:0] b);
    return (a > 0 && b < 0) || (a < 0 && b > 0);
  endfunction

  function automatic vec_t cross_point(vec_t pa, vec_t pb,
                                       logic signed [63:0] da, logic signed [63:0] db);
    logic [63:0] num, den, t;
    logic signed [63:0] d;
    coord_t a[3], b[3], r[3];
    vec_t res;
    num = da < 0 ? -da : da;
    den = num + (db < 0 ? -db : db);
    while (den >= 64'h8000_0000) begin
      den = den >> 1;
      num = num >> 1;
    end
    if (den == 0) den = 1;
    t = (num << 31) / den;
    a = '{pa.x, pa.y, pa.z};
    b = '{pb.x, pb.y, pb.z};
    for (int k = 0; k < 3; k++) begin
      d = 64'(b[k]) - 64'(a[k]);
      r[k] = coord_t'(64'(a[k]) + floor_shift(d * $signed(t), 31));
    end
    res.x = r[0];
    res.y = r[1];
    res.z = r[2];
    return res;
  endfunction

  task automatic predict_pieces(in_t t);
    vec_t v[3];
    logic signed [63:0] d[3];
    bit c01, c12, c20, fvf;
    vec_t ca, cb;
    logic [2:0] crn[4];
    int side[3];
    out_t o;
    v[0] = '{t.v0_x, t.v0_y, t.v0_z};
    v[1] = '{t.v1_x, t.v1_y, t.v1_z};
    v[2] = '{t.v2_x, t.v2_y, t.v2_z};
    for (int i = 0; i < 3; i++) d[i] = dist_of(v[i].x, v[i].y, v[i].z);
    fvf = d[0] > 0;
    c01 = sign_flip(d[0], d[1]);
    c12 = sign_flip(d[1], d[2]);
    c20 = sign_flip(d[2], d[0]);
    n_tris++;
    o = '0;
    o.first_vertex_front = fvf;
    if (c01 && c12) begin
      ca = cross_point(v[0], v[1], d[0], d[1]);
      cb = cross_point(v[1], v[2], d[1], d[2]);
      crn = '{CORNER_V1, CORNER_CUT_B, CORNER_V2, CORNER_V0};
      side = '{1, 2, 0};
    end else if (c01 && c20) begin
      ca = cross_point(v[0], v[1], d[0], d[1]);
      cb = cross_point(v[2], v[0], d[2], d[0]);
      crn = '{CORNER_V1, CORNER_V2, CORNER_CUT_B, CORNER_V0};
      side = '{1, 2, 0};
    end else if (c12 && c20) begin
      ca = cross_point(v[1], v[2], d[1], d[2]);
      cb = cross_point(v[2], v[0], d[2], d[0]);
      crn = '{CORNER_V2, CORNER_CUT_B, CORNER_V0, CORNER_V1};
      side = '{2, 0, 1};
    end else begin
      o.last_piece = 1'b1;
      piece_q.insert(piece_q.size(), o);
      return;
    end
    n_split++;
    for (int n = 0; n < 3; n++) begin
      o.split_done  = 1'b1;
      o.piece_front = d[side[n]] > 0;
      o.corner_b    = crn[n];
      o.corner_c    = crn[n+1];
      o.cut_a_x = ca.x; o.cut_a_y = ca.y; o.cut_a_z = ca.z;
      o.cut_b_x = cb.x; o.cut_b_y = cb.y; o.cut_b_z = cb.z;
      o.last_piece = n == 2;
      piece_q.insert(piece_q.size(), o);
    end
  endtask

  function automatic bit idle_now();
    return !quiet && $urandom_range(99) < 11;
  endfunction

  // Output side: random stall, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || idle_now();
    end
  end

  always @(posedge clk) begin
    out_t exp_b;
    if (rst_n && out_valid && !out_stall) begin
      n_beats++;
      if (piece_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected beat %h", out_data);
      end else begin
        exp_b = piece_q.pop_front();
        if (out_data.last_piece && typed_q.size() > 0 && typed_on_q[0]) begin
          if (typed_q[0] !== exp_b) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Typed beat %h disagrees with predictor %h", typed_q[0], exp_b);
          end
        end
        if (out_data.last_piece && typed_q.size() > 0) begin
          void'(typed_q.pop_front());
          void'(typed_on_q.pop_front());
        end
        if (out_data.split_done !== exp_b.split_done ||
            out_data.first_vertex_front !== exp_b.first_vertex_front ||
            out_data.piece_front !== exp_b.piece_front ||
            out_data.corner_b !== exp_b.corner_b ||
            out_data.corner_c !== exp_b.corner_c ||
            out_data.cut_a_x !== exp_b.cut_a_x || out_data.cut_a_y !== exp_b.cut_a_y ||
            out_data.cut_a_z !== exp_b.cut_a_z || out_data.cut_b_x !== exp_b.cut_b_x ||
            out_data.cut_b_y !== exp_b.cut_b_y || out_data.cut_b_z !== exp_b.cut_b_z ||
            out_data.last_piece !== exp_b.last_piece) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Beat mismatch: expected %h actual %h", exp_b, out_data);
        end
      end
    end
  end

  // Valid stays high from one beat to the next unless the sender idles.
  task automatic send_tri(in_t t, bit has_beat, out_t beat);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk iff !in_stall);
    predict_pieces(t);
    typed_q.insert(typed_q.size(), beat);
    typed_on_q.insert(typed_on_q.size(), has_beat);
  endtask

  task automatic write_reg(cfg_idx_t idx, coord_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk iff cfg_ready);
    case (idx)
      CFG_NORMAL_X: plane.normal_x = val;
      CFG_NORMAL_Y: plane.normal_y = val;
      CFG_NORMAL_Z: plane.normal_z = val;
      default:      plane.plane_offset = val;
    endcase
  endtask

  task automatic drain();
    while (piece_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_plane(coord_t nx, coord_t ny, coord_t nz, coord_t off);
    in_valid <= 1'b0;
    drain();
    write_reg(CFG_NORMAL_X, nx);
    write_reg(CFG_NORMAL_Y, ny);
    write_reg(CFG_NORMAL_Z, nz);
    write_reg(CFG_PLANE_OFFSET, off);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(in_t t, bit has_beat, out_t beat);
    row_t r;
    r.tri_in   = t;
    r.has_beat = has_beat;
    r.beat     = beat;
    rows.insert(rows.size(), r);
  endtask

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(2 << 16)) - (1 << 16));
      default: return coord_t'($signed($urandom_range(1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic in_t rnd_tri(int mode);
    in_t t;
    t.v0_x = rnd_coord(mode); t.v0_y = rnd_coord(mode); t.v0_z = rnd_coord(mode);
    t.v1_x = rnd_coord(mode); t.v1_y = rnd_coord(mode); t.v1_z = rnd_coord(mode);
    t.v2_x = rnd_coord(mode); t.v2_y = rnd_coord(mode); t.v2_z = rnd_coord(mode);
    return t;
  endfunction

  function automatic in_t mk_tri(coord_t z0, coord_t z1, coord_t z2);
    in_t t;
    t = '0;
    t.v0_x = 32'sh0001_0000; t.v0_z = z0;
    t.v1_y = 32'sh0001_0000; t.v1_z = z1;
    t.v2_x = -32'sh0001_0000; t.v2_z = z2;
    return t;
  endfunction

  function automatic out_t not_split(bit fvf);
    out_t o;
    o = '0;
    o.first_vertex_front = fvf;
    o.last_piece = 1'b1;
    return o;
  endfunction

  initial begin
    out_t none;
    in_t  t;
    coord_t big, neg;
    none = '0;
    big = 32'sh7fff_ffff;
    neg = -32'sh8000_0000;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    mismatches = 0; cycles = 0; n_tris = 0; n_split = 0; n_beats = 0;
    quiet = 1'b0; hold_off = 1'b0;
    plane.normal_x = NORMAL_X_RST; plane.normal_y = NORMAL_Y_RST;
    plane.normal_z = NORMAL_Z_RST; plane.plane_offset = PLANE_OFFSET_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under the reset plane z = 0.
    add_row(mk_tri(32'sh10000, 32'sh10000, 32'sh10000), 1, not_split(1));
    add_row(mk_tri(-32'sh10000, -32'sh10000, -32'sh10000), 1, not_split(0));
    add_row(mk_tri(0, 32'sh10000, -32'sh10000), 1, not_split(0));
    add_row(mk_tri(0, 0, 0), 1, not_split(0));
    add_row(mk_tri(32'sh10000, -32'sh10000, 32'sh10000), 0, none);
    add_row(mk_tri(32'sh10000, 32'sh10000, -32'sh10000), 0, none);
    add_row(mk_tri(-32'sh10000, 32'sh10000, 32'sh10000), 0, none);
    add_row(mk_tri(big, neg, big), 0, none);
    add_row(mk_tri(neg, big, big), 0, none);
    add_row(mk_tri(1, -1, 1), 0, none);
    t = '1;
    add_row(t, 1, not_split(0));
    t = '0;
    t.v0_x = big; t.v0_y = neg; t.v0_z = big;
    t.v1_x = neg; t.v1_y = big; t.v1_z = neg;
    t.v2_x = big; t.v2_y = big; t.v2_z = 1;
    add_row(t, 0, none);
    foreach (rows[i]) send_tri(rows[i].tri_in, rows[i].has_beat, rows[i].beat);

    // A zero normal never splits, whatever the offset. Then an extreme plane gets random triangles.
    set_plane(0, 0, 0, neg);
    send_tri(mk_tri(big, neg, big), 1, not_split(0));
    send_tri(mk_tri(neg, big, 0), 1, not_split(0));
    set_plane(0, 0, 0, big);
    send_tri(mk_tri(big, neg, big), 1, not_split(1));
    set_plane(big, neg, big, neg);
    for (int i = 0; i < 6; i++) send_tri(rnd_tri(0), 0, none);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_plane(32'sh10000, 32'sh8000, -32'sh4000, 32'sh100);
        1: set_plane(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom));
        2: set_plane(neg, big, neg, big);
        3: set_plane(rnd_coord(1), rnd_coord(1), rnd_coord(1), rnd_coord(1));
        default: set_plane(0, 0, NORMAL_Z_RST, 0);
      endcase
      quiet = ph == 3;
      for (int i = 0; i < 40; i++) begin
        send_tri(rnd_tri(ph == 1 || ph == 2 ? 0 : $urandom_range(1, 2)), 0, none);
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    drain();
    $display("Sent %0d triangles (%0d split), checked %0d output beats",
             n_tris, n_split, n_beats);
    $display("Covered reset plane, zero normal, extreme and random planes");
    if (mismatches == 0 && typed_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Long output hold-off counted in cycles while triangles keep arriving.
  initial begin
    @(posedge rst_n);
    wait (n_tris > 60);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
design/tps_pkg.sv
design/tps_front.sv
design/tps_queue.sv
design/tps_back.sv
design/triangle_plane_splitter_top.sv
bench/tb.sv
